// ===== rtl/msh_pkg.sv =====
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types and constants of the multi-format sample histogram.
// ----------------------------------------------------------------------------
package msh_pkg;

  // fixed geometry
  localparam int BINS           = 256;
  localparam int BIN_W          = 8;
  localparam int CH_W           = 2;
  localparam int FMT_W          = 2;
  localparam int SAMPLE_W       = 64;
  localparam int CHANNELS_DEF   = 3;
  localparam int COUNT_BITS_DEF = 21;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // sample encodings
  typedef enum logic [FMT_W-1:0] {
    FMT_U8  = 2'd0,
    FMT_U16 = 2'd1,
    FMT_F32 = 2'd2,
    FMT_F64 = 2'd3
  } fmt_t;

  // store sequencer states
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } st_t;

  // one accepted command on its way into the store
  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [CH_W-1:0]  channel;
    logic [BIN_W-1:0] bin;
  } msh_op_t;

  // store status seen by the front end
  typedef struct packed {
    logic       busy;
    logic [1:0] reads;
  } msh_status_t;

endpackage

// ===== rtl/msh_if.sv =====
// ----------------------------------------------------------------------------
// msh_if
// Valid/ready channels: command requests and bin count responses.
// ----------------------------------------------------------------------------
interface msh_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [msh_pkg::CH_W-1:0]    channel;
  logic [msh_pkg::SAMPLE_W-1:0] sample;
  logic [msh_pkg::BIN_W-1:0]   bin_index;

  modport source (output valid, command, channel, sample, bin_index, input ready);
  modport sink   (input valid, command, channel, sample, bin_index, output ready);
endinterface

interface msh_rsp_if #(
  parameter int COUNT_BITS = msh_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

// ===== rtl/multiformat_sample_histogram.sv =====
// ----------------------------------------------------------------------------
// multiformat_sample_histogram
// 256-bin per-channel histogram of samples in uint8/uint16/float32/float64.
// ----------------------------------------------------------------------------
// Commands arrive on req (valid/ready): clear all bins, add one sample to a
// channel, or read one bin. Only reads produce a transfer on rsp, carrying the
// bin count, in command order. cfg_wr_en/cfg_wr_data set the sample format;
// write it only while the block is idle.
// Throughput: one command per cycle for add and read while req.ready is high,
// set by the single read-modify-write port of the count memory; back-to-back
// adds to the same bin are forwarded. A read result passes the op0 and op1
// stage registers and the result queue on its way to rsp. A clear holds
// req.ready low while a sweep writes zero into the memory one entry per cycle.
// Reset starts the same sweep, with req.ready low; the format returns to
// uint16.
// A stalled rsp fills a four-entry result queue; outside a clear, req.ready
// drops only when results already queued plus reads in flight would overflow
// it, so adds and reads keep flowing while a result waits.
// ----------------------------------------------------------------------------
module multiformat_sample_histogram #(
  parameter int CHANNELS   = msh_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = msh_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [msh_pkg::FMT_W-1:0] cfg_wr_data,
  msh_req_if.sink                   req,
  msh_rsp_if.source                 rsp
);
  import msh_pkg::*;

  fmt_t                  fmt;
  logic [BIN_W-1:0]      sample_bin;
  msh_op_t               op;
  msh_status_t           status;
  logic                  res_valid;
  logic [COUNT_BITS-1:0] res_count;
  logic                  accept;

  logic [COUNT_BITS-1:0] q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr;
  logic [Q_PTR_W-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0]    q_count;
  logic                  push;
  logic                  pop;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_U16;
    end else if (cfg_wr_en) begin
      fmt <= fmt_t'(cfg_wr_data);
    end
  end

  // sample to bin
  msh_bin u_bin (
    .fmt    (fmt),
    .sample (req.sample),
    .bin    (sample_bin)
  );

  // accept when not clearing and the result queue has room for reads in flight
  assign req.ready = !status.busy && (q_count + {1'b0, status.reads}) < 3'(Q_DEPTH);
  assign accept    = req.valid && req.ready;

  assign op.valid   = accept;
  assign op.cmd     = cmd_t'(req.command);
  assign op.channel = req.channel;
  assign op.bin     = (cmd_t'(req.command) == CMD_READ) ? req.bin_index : sample_bin;

  msh_store #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .op_in     (op),
    .status    (status),
    .res_valid (res_valid),
    .res_count (res_count)
  );

  // result queue
  assign push = res_valid;
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + {2'b0, push} - {2'b0, pop};
    end
  end

  assign rsp.valid     = q_count != '0;
  assign rsp.bin_count = q_mem[rd_ptr];

  // checks
  a_queue_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> q_count < 3'(Q_DEPTH))
    else $error("result queue overflow");

  a_credit_bound : assert property (@(posedge clk) disable iff (rst)
    q_count + {1'b0, status.reads} <= 3'(Q_DEPTH))
    else $error("reads in flight exceed queue room");

endmodule

// ===== rtl/msh_bin.sv =====
// ----------------------------------------------------------------------------
// msh_bin
// Maps a raw sample in the selected encoding to a bin from 0 to 255.
// ----------------------------------------------------------------------------
module msh_bin (
  input  msh_pkg::fmt_t                 fmt,
  input  logic [msh_pkg::SAMPLE_W-1:0]  sample,
  output logic [msh_pkg::BIN_W-1:0]     bin
);
  import msh_pkg::*;

  // single precision fields
  logic        sgn32;
  logic [7:0]  e32;
  logic [22:0] m32;
  logic [7:0]  sh32;
  logic [23:0] shifted32;
  logic [7:0]  bin32;

  // double precision fields
  logic        sgn64;
  logic [10:0] e64;
  logic [51:0] m64;
  logic [23:0] q24;
  logic [28:0] rem64;
  logic        round_up;
  logic [24:0] q25;
  logic [10:0] sh64;
  logic [24:0] shifted64;
  logic [7:0]  bin64;

  localparam logic [28:0] HALF64 = 29'h1000_0000;

  // float32: clamp to [0,1], nan as one, floor(v*256)
  assign sgn32     = sample[31];
  assign e32       = sample[30:23];
  assign m32       = sample[22:0];
  assign sh32      = 8'd142 - e32;
  assign shifted32 = {1'b1, m32} >> sh32[4:0];

  always_comb begin
    if (e32 == 8'hFF && m32 != '0) begin
      bin32 = 8'hFF;
    end else if (sgn32) begin
      bin32 = 8'h00;
    end else if (e32 >= 8'd127) begin
      bin32 = 8'hFF;
    end else if (e32 == 8'd0) begin
      bin32 = 8'h00;
    end else if (sh32 >= 8'd32) begin
      bin32 = 8'h00;
    end else begin
      bin32 = shifted32[7:0];
    end
  end

  // float64: clamp, round to 24 significand bits (ties to even), then bin
  assign sgn64     = sample[63];
  assign e64       = sample[62:52];
  assign m64       = sample[51:0];
  assign q24       = {1'b1, m64[51:29]};
  assign rem64     = m64[28:0];
  assign round_up  = (rem64 > HALF64) || (rem64 == HALF64 && q24[0]);
  assign q25       = {1'b0, q24} + {24'd0, round_up};
  assign sh64      = 11'd1038 - e64;
  assign shifted64 = q25 >> sh64[4:0];

  always_comb begin
    if (e64 == 11'h7FF && m64 != '0) begin
      bin64 = 8'hFF;
    end else if (sgn64) begin
      bin64 = 8'h00;
    end else if (e64 >= 11'd1023) begin
      bin64 = 8'hFF;
    end else if (e64 < 11'd1014) begin
      bin64 = 8'h00;
    end else if (shifted64[24:8] != '0) begin
      bin64 = 8'hFF;
    end else begin
      bin64 = shifted64[7:0];
    end
  end

  // format select; uint16 scaling by 256/65535 reduces to the high byte
  always_comb begin
    case (fmt)
      FMT_U8:  bin = sample[7:0];
      FMT_U16: bin = sample[15:8];
      FMT_F32: bin = bin32;
      default: bin = bin64;
    endcase
  end

endmodule

// ===== rtl/msh_store.sv =====
// ----------------------------------------------------------------------------
// msh_store
// Count memory with read-modify-write, write forwarding and clearing sweep.
// ----------------------------------------------------------------------------
module msh_store #(
  parameter int CHANNELS   = msh_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = msh_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  msh_pkg::msh_op_t       op_in,
  output msh_pkg::msh_status_t   status,
  output logic                   res_valid,
  output logic [COUNT_BITS-1:0]  res_count
);
  import msh_pkg::*;

  localparam int DEPTH  = CHANNELS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

  // count memory with registered read
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;

  msh_op_t               op0;
  msh_op_t               op1;
  st_t                   state;
  st_t                   state_next;
  logic [ADDR_W-1:0]     sweep_cnt;
  logic                  sweep_we;
  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  logic [CH_W+BIN_W-1:0] addr0_full;
  logic [CH_W+BIN_W-1:0] addr1_full;
  logic [ADDR_W-1:0]     addr0;
  logic [ADDR_W-1:0]     addr1;
  logic                  ch_ok1;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic                  op_we;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // addresses of both stages
  assign addr0_full = {op0.channel, op0.bin};
  assign addr1_full = {op1.channel, op1.bin};
  assign addr0      = addr0_full[ADDR_W-1:0];
  assign addr1      = addr1_full[ADDR_W-1:0];
  assign ch_ok1     = {1'b0, op1.channel} < 3'(CHANNELS);

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op0.valid <= 1'b0;
      op1.valid <= 1'b0;
    end else begin
      op0.valid <= op_in.valid;
      op1.valid <= op0.valid;
    end
    op0.cmd     <= op_in.cmd;
    op0.channel <= op_in.channel;
    op0.bin     <= op_in.bin;
    op1.cmd     <= op0.cmd;
    op1.channel <= op0.channel;
    op1.bin     <= op0.bin;
  end

  // forward the write that lands together with this stage's read
  assign cur = (fwd_valid && fwd_addr == addr1) ? fwd_data : rdata;
  assign inc = (cur == CNT_MAX) ? cur : cur + 1'b1;

  assign op_we     = op1.valid && op1.cmd == CMD_ADD && ch_ok1;
  assign mem_we    = op_we || sweep_we;
  assign mem_waddr = sweep_we ? sweep_cnt : addr1;
  assign mem_wdata = sweep_we ? '0 : inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= op_we;
    end
    fwd_addr <= addr1;
    fwd_data <= inc;
  end

  // read results
  assign res_valid = op1.valid && op1.cmd == CMD_READ;
  assign res_count = ch_ok1 ? cur : '0;

  // sequencer: clearing sweep after reset and on each clear command
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep_cnt <= (sweep_cnt == LAST_ADDR) ? '0 : sweep_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    case (state)
      ST_CLEAR: state_next = (sweep_cnt == LAST_ADDR) ? ST_RUN : ST_CLEAR;
      ST_RUN:   state_next = (op0.valid && op0.cmd == CMD_CLEAR) ? ST_CLEAR : ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: sweep_we = 1'b1;
      default:  sweep_we = 1'b0;
    endcase
  end

  // status toward the front end
  assign status.busy  = state == ST_CLEAR || (op0.valid && op0.cmd == CMD_CLEAR);
  assign status.reads = {1'b0, op0.valid && op0.cmd == CMD_READ}
                      + {1'b0, op1.valid && op1.cmd == CMD_READ};

  // checks
  a_no_op_in_sweep : assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !op_in.valid && !op_we)
    else $error("command accepted during clearing sweep");

  a_clear_starts_sweep : assert property (@(posedge clk) disable iff (rst)
    op0.valid && op0.cmd == CMD_CLEAR |=> state == ST_CLEAR)
    else $error("clear command did not start sweep");

  a_incr_nonzero : assert property (@(posedge clk) disable iff (rst)
    op_we |-> mem_wdata != '0)
    else $error("counter wrapped to zero");

endmodule

// ===== sim/tb_multiformat_sample_histogram.sv =====
// ----------------------------------------------------------------------------
// tb_multiformat_sample_histogram
// Self-checking testbench of the multi-format sample histogram.
// ----------------------------------------------------------------------------
// Drives clear/add/read commands on the request channel and keeps its own
// copy of the bin store and the sample format. Each read predicts one count;
// every response transfer is checked against the oldest prediction. Directed
// tests cover the format edges (NaN, signed zero, infinity, rounding up to
// one, subnormals, out-of-range channel, unused command), then random phases
// run each format, all but the uint8 phase with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_multiformat_sample_histogram;
  import msh_pkg::*;

  localparam int          CH_NUM     = CHANNELS_DEF;
  localparam int          COUNT_W    = COUNT_BITS_DEF;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  // response latency plus margin, used for the quiet time before a write
  localparam int          SETTLE_CYCLES = 8;
  localparam int          IDLE_PCT      = 24;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [FMT_W-1:0] cfg_wr_data;

  msh_req_if                         req_if ();
  msh_rsp_if #(.COUNT_BITS(COUNT_W)) rsp_if ();

  multiformat_sample_histogram #(
    .CHANNELS  (CH_NUM),
    .COUNT_BITS(COUNT_W)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // shadow copy of the histogram
  logic [COUNT_W-1:0] bin_model [0:CH_NUM-1][0:BINS-1];
  fmt_t               fmt_model;
  logic [COUNT_W-1:0] pending_counts [$];
  logic [BIN_W-1:0]   last_bin [0:3];
  int                 fail_count;
  bit                 allow_idle;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // response back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= !allow_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic report_failure(input string msg);
    if (fail_count < 10) begin
      $display("%s", msg);
    end
    fail_count++;
  endtask

  // response checker
  always @(posedge clk) begin : count_check
    logic [COUNT_W-1:0] want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_counts.size() == 0) begin
        report_failure($sformatf("unexpected response: bin_count %0d", rsp_if.bin_count));
      end else begin
        want = pending_counts.pop_front();
        if (rsp_if.bin_count !== want) begin
          report_failure($sformatf("bin_count mismatch: expected %0d, got %0d",
                                   want, rsp_if.bin_count));
        end
      end
    end
  end

  // float32 bits to bin
  function automatic logic [7:0] f32_to_bin(input logic [31:0] b);
    int          sh;
    logic [23:0] sig;
    if (b[30:23] == 8'hFF && b[22:0] != 0) return 8'd255;  // NaN as one
    if (b[31]) return 8'd0;                                 // negatives, -0
    if (b[30:23] >= 8'd127) return 8'd255;
    if (b[30:23] == 8'd0) return 8'd0;                      // zero, subnormals
    sh  = 142 - int'(b[30:23]);
    if (sh >= 32) return 8'd0;
    sig = {1'b1, b[22:0]};
    return 8'(sig >> sh);
  endfunction

  // float64 bits to bin, rounding to single first
  function automatic logic [7:0] f64_to_bin(input logic [63:0] b);
    logic [52:0] sig;
    logic [24:0] q;
    logic [28:0] rem;
    int          sh;
    if (b[62:52] == 11'h7FF && b[51:0] != 0) return 8'd255;
    if (b[63]) return 8'd0;
    if (b[62:52] >= 11'd1023) return 8'd255;
    if (b[62:52] < 11'd1014) return 8'd0;
    sig = {1'b1, b[51:0]};
    q   = {1'b0, sig[52:29]};
    rem = sig[28:0];
    // round to nearest, ties to even
    if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && q[0])) q = q + 25'd1;
    sh = 1038 - int'(b[62:52]);
    q  = q >> sh;
    return (q > 25'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [7:0] sample_to_bin(input fmt_t f, input logic [63:0] s);
    logic [63:0] v;
    case (f)
      FMT_U8: begin
        v = ({56'd0, s[7:0]} * 64'd256) / 64'd255;
        return (v > 64'd255) ? 8'd255 : v[7:0];
      end
      FMT_U16: begin
        v = ({48'd0, s[15:0]} * 64'd256) / 64'd65535;
        return (v > 64'd255) ? 8'd255 : v[7:0];
      end
      FMT_F32: return f32_to_bin(s[31:0]);
      default: return f64_to_bin(s);
    endcase
  endfunction

  // one request transfer; entered and left just after a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] ch,
                           input logic [63:0] smp, input logic [7:0] bin);
    logic [7:0] idx;
    while (allow_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.channel   <= ch;
    req_if.sample    <= smp;
    req_if.bin_index <= bin;
    do @(posedge clk); while (!req_if.ready);
    // update the shadow store on the transfer
    case (cmd)
      CMD_CLEAR: begin
        for (int c = 0; c < CH_NUM; c++)
          for (int i = 0; i < BINS; i++) bin_model[c][i] = '0;
      end
      CMD_ADD: begin
        if (ch < CH_NUM) begin
          idx = sample_to_bin(fmt_model, smp);
          if (bin_model[ch][idx] != COUNT_MAX) bin_model[ch][idx]++;
          last_bin[ch] = idx;
        end
      end
      CMD_READ: begin
        pending_counts.insert(pending_counts.size(),
                              (ch < CH_NUM) ? bin_model[ch][bin] : '0);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait until all reads are answered and the block is idle again
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic set_format(input fmt_t f);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    fmt_model    = f;
  endtask

  function automatic logic [63:0] random_sample(input fmt_t f);
    logic [63:0] r;
    int          pick;
    r    = {$urandom(), $urandom()};
    pick = $urandom_range(0, 9);
    case (f)
      FMT_F32: begin
        if (pick < 6) begin
          r[30:23] = 8'($urandom_range(110, 127));
          r[31]    = (pick == 0);
        end else if (pick == 6) begin
          r[30:23] = 8'hFF;
        end else if (pick == 7) begin
          r[30:23] = 8'h00;
        end
      end
      FMT_F64: begin
        if (pick < 6) begin
          r[62:52] = 11'($urandom_range(1008, 1024));
          r[63]    = (pick == 0);
        end else if (pick == 6) begin
          r[62:52] = 11'h7FF;
        end else if (pick == 7) begin
          // halfway between two singles
          r[62:52] = 11'($urandom_range(1014, 1022));
          r[63]    = 1'b0;
          r[28:0]  = 29'h1000_0000;
        end
      end
      default: begin
        if (pick == 0) r[15:0] = 16'hFFFF;
        else if (pick == 1) r[15:0] = 16'h0000;
      end
    endcase
    return r;
  endfunction

  // reset value of the format is uint16; also bin read on a missing channel
  task automatic test_uint16_after_reset();
    send_item(CMD_READ, 2'd3, '0, 8'd255);
    send_item(CMD_ADD, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    send_item(CMD_ADD, 2'd0, 64'h0000_0000_0000_0000, 8'd0);
    send_item(CMD_ADD, 2'd0, 64'h0000_0000_0000_8000, 8'd0);
    send_item(CMD_READ, 2'd0, '0, 8'd255);
    send_item(CMD_READ, 2'd0, '0, 8'd128);
  endtask

  task automatic test_uint8_bins();
    set_format(FMT_U8);
    send_item(CMD_ADD, 2'd1, 64'hFFFF_FFFF_FFFF_FF00, 8'd0);
    send_item(CMD_ADD, 2'd1, 64'h0000_0000_0000_00FF, 8'd0);
    send_item(CMD_READ, 2'd1, '0, 8'd255);
    send_item(CMD_READ, 2'd1, '0, 8'd0);
  endtask

  task automatic test_float32_bins();
    set_format(FMT_F32);
    send_item(CMD_ADD, 2'd2, 64'h0000_0000_7FC0_0000, 8'd0);  // NaN
    send_item(CMD_ADD, 2'd2, 64'hFFFF_FFFF_8000_0000, 8'd0);  // -0
    send_item(CMD_ADD, 2'd2, 64'h0000_0000_7F80_0000, 8'd0);  // +inf
    send_item(CMD_ADD, 2'd2, 64'h0000_0000_3F7F_FFFF, 8'd0);  // just under one
    send_item(CMD_ADD, 2'd2, 64'h0000_0000_3B80_0000, 8'd0);  // 2^-8
    send_item(CMD_ADD, 2'd2, 64'h0000_0000_0000_0001, 8'd0);  // subnormal
    send_item(CMD_READ, 2'd2, '0, 8'd255);
    send_item(CMD_READ, 2'd2, '0, 8'd0);
    send_item(CMD_READ, 2'd2, '0, 8'd1);
  endtask

  task automatic test_float64_bins();
    set_format(FMT_F64);
    send_item(CMD_ADD, 2'd0, 64'h3FEF_FFFF_FFFF_FFFF, 8'd0);  // rounds up to one
    send_item(CMD_ADD, 2'd0, 64'h7FF8_0000_0000_0000, 8'd0);  // NaN
    send_item(CMD_ADD, 2'd0, 64'hBFF0_0000_0000_0000, 8'd0);  // -1.0
    send_item(CMD_READ, 2'd0, '0, 8'd255);
  endtask

  // unused command and missing channel leave the store alone, then clear
  task automatic test_clear_and_ignored();
    send_item(CMD_UNUSED, 2'd0, '0, 8'd0);
    send_item(CMD_ADD, 2'd3, 64'h3FF0_0000_0000_0000, 8'd0);
    send_item(CMD_READ, 2'd0, '0, 8'd255);
    send_item(CMD_CLEAR, 2'd0, '0, 8'd0);
    send_item(CMD_READ, 2'd0, '0, 8'd255);
  endtask

  task automatic test_random_phase(input fmt_t f, input int n_items, input bit quiet);
    int         done;
    int         roll;
    logic [1:0] ch;
    logic [7:0] bin;
    set_format(f);
    allow_idle = !quiet;
    done       = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 999);
      ch   = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      bin  = ($urandom_range(0, 1) == 0) ? last_bin[ch] : 8'($urandom_range(0, 255));
      if (roll < 5) begin
        send_item(CMD_CLEAR, ch, {$urandom(), $urandom()}, bin);
        done++;
      end else if (roll < 520) begin
        send_item(CMD_ADD, ch, random_sample(f), bin);
        if (ch < CH_NUM) done++;
      end else if (roll < 960) begin
        send_item(CMD_READ, ch, {$urandom(), $urandom()}, bin);
        done++;
      end else begin
        send_item(CMD_UNUSED, ch, {$urandom(), $urandom()}, bin);
      end
    end
    allow_idle = 1'b1;
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    req_if.valid     = 1'b0;
    req_if.command   = '0;
    req_if.channel   = '0;
    req_if.sample    = '0;
    req_if.bin_index = '0;
    rsp_if.ready     = 1'b0;
    allow_idle       = 1'b1;
    fail_count       = 0;
    fmt_model        = FMT_U16;
    for (int c = 0; c < 4; c++) last_bin[c] = '0;
    for (int c = 0; c < CH_NUM; c++)
      for (int i = 0; i < BINS; i++) bin_model[c][i] = '0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_uint16_after_reset();
    test_uint8_bins();
    test_float32_bins();
    test_float64_bins();
    test_clear_and_ignored();
    test_random_phase(FMT_F32, 170, 1'b0);
    test_random_phase(FMT_U8, 170, 1'b1);
    test_random_phase(FMT_F64, 170, 1'b0);
    test_random_phase(FMT_U16, 170, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
